// File: hw/rtl/utcd_pkg.sv
// shared types and constants for the utf-8 to code point decoder
`timescale 1ns / 1ps

package utcd_pkg;

    localparam int unsigned COUNT_WIDTH_DEFAULT = 32;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned CAP_W  = 32;
    localparam int unsigned OUT_COUNT_W = 32;

    // lead byte thresholds
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'b1100_0000;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'b1110_0000;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'b1111_0000;

    // payload masks
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    typedef enum logic [1:0] {
        LEAD_SINGLE,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR
    } lead_class_t;

    // one classified byte as it sits in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
        lead_class_t       lead_class;
    } utcd_item_t;

endpackage

// File: hw/rtl/utcd_if.sv
// valid/ready channels for input bytes and decoded words
`timescale 1ns / 1ps

interface utcd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [utcd_pkg::BYTE_W-1:0]   data_byte;
    logic                          end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utcd_cp_if;
    logic                              valid;
    logic                              ready;
    logic [utcd_pkg::CP_W-1:0]         code_point;
    logic                              code_point_valid;
    logic [utcd_pkg::OUT_COUNT_W-1:0]  decoded_count;
    logic                              string_done;
    logic                              overflow;
    logic                              truncated;

    modport source (output valid, output code_point, output code_point_valid,
                    output decoded_count, output string_done, output overflow,
                    output truncated, input ready);
    modport sink   (input valid, input code_point, input code_point_valid,
                    input decoded_count, input string_done, input overflow,
                    input truncated, output ready);
endinterface

// File: hw/rtl/utcd_front.sv
// front end: accepts bytes and classifies them by lead byte length
`timescale 1ns / 1ps

module utcd_front
(
    utcd_byte_if.sink           byte_in,
    input  logic                queue_full,
    output logic                push,
    output utcd_pkg::utcd_item_t push_item
);

    utcd_pkg::lead_class_t lead_class;

    always_comb
    begin
        if (byte_in.data_byte < utcd_pkg::LEAD2_MIN)
        begin
            lead_class = utcd_pkg::LEAD_SINGLE;
        end
        else if (byte_in.data_byte < utcd_pkg::LEAD3_MIN)
        begin
            lead_class = utcd_pkg::LEAD_TWO;
        end
        else if (byte_in.data_byte < utcd_pkg::LEAD4_MIN)
        begin
            lead_class = utcd_pkg::LEAD_THREE;
        end
        else
        begin
            lead_class = utcd_pkg::LEAD_FOUR;
        end
    end

    assign byte_in.ready = !queue_full;
    assign push          = byte_in.valid && !queue_full;

    assign push_item.data_byte     = byte_in.data_byte;
    assign push_item.end_of_string = byte_in.end_of_string;
    assign push_item.lead_class    = lead_class;

endmodule

// File: hw/rtl/utcd_queue.sv
// small register queue between front and back
`timescale 1ns / 1ps

module utcd_queue
#(
    parameter int unsigned DEPTH = utcd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utcd_pkg::utcd_item_t push_item,
    input  logic                 pop,
    output utcd_pkg::utcd_item_t pop_item,
    output logic                 full,
    output logic                 empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utcd_pkg::utcd_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

endmodule

// File: hw/rtl/utcd_back.sv
// back end: assembles code points, counts them and drives the output register
`timescale 1ns / 1ps

module utcd_back
#(
    parameter int unsigned COUNT_WIDTH = utcd_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [utcd_pkg::CAP_W-1:0]  capacity,
    input  logic                        queue_empty,
    input  utcd_pkg::utcd_item_t        item,
    output logic                        pop,
    utcd_cp_if.source                   cp_out
);

    // count never needs more than the 32 bits of the result field
    localparam int unsigned CNT_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
    localparam int unsigned CP_W  = utcd_pkg::CP_W;

    logic [1:0]      rem_reg, rem_next;
    logic [CP_W-1:0] part_reg, part_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            ovf_reg, ovf_next;

    logic                               out_valid_reg, out_valid_next;
    logic [CP_W-1:0]                    out_cp_reg, out_cp_next;
    logic                               out_cpv_reg, out_cpv_next;
    logic [utcd_pkg::OUT_COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                               out_done_reg, out_done_next;
    logic                               out_ovf_reg, out_ovf_next;
    logic                               out_trunc_reg, out_trunc_next;

    logic            can_step;
    logic [1:0]      step_rem;
    logic [CP_W-1:0] step_part;
    logic [CP_W-1:0] step_cp;
    logic            complete;
    logic            stored;
    logic            saturated;
    logic [CNT_W-1:0] step_count;
    logic            step_ovf;
    logic            trunc;

    assign can_step = !out_valid_reg || cp_out.ready;
    assign pop      = !queue_empty && can_step;

    // one byte of decode work
    always_comb
    begin
        step_rem   = rem_reg;
        step_part  = part_reg;
        step_cp    = '0;
        complete   = 1'b0;
        stored     = 1'b0;
        step_count = count_reg;
        step_ovf   = ovf_reg;
        saturated  = (count_reg == '1);

        if (rem_reg != 2'd0)
        begin
            step_part = {part_reg[CP_W-7:0], item.data_byte[5:0]};
            step_rem  = rem_reg - 2'd1;
            if (rem_reg == 2'd1)
            begin
                complete = 1'b1;
                step_cp  = step_part;
            end
        end
        else
        begin
            unique case (item.lead_class)
                utcd_pkg::LEAD_SINGLE:
                begin
                    complete = 1'b1;
                    step_cp  = CP_W'(item.data_byte);
                end
                utcd_pkg::LEAD_TWO:
                begin
                    step_part = CP_W'(item.data_byte & utcd_pkg::LEAD2_MASK);
                    step_rem  = 2'd1;
                end
                utcd_pkg::LEAD_THREE:
                begin
                    step_part = CP_W'(item.data_byte & utcd_pkg::LEAD3_MASK);
                    step_rem  = 2'd2;
                end
                utcd_pkg::LEAD_FOUR:
                begin
                    step_part = CP_W'(item.data_byte & utcd_pkg::LEAD4_MASK);
                    step_rem  = 2'd3;
                end
                default:
                begin
                    step_rem = 2'd0;
                end
            endcase
        end

        if (complete)
        begin
            step_part = '0;
            if (capacity != '0)
            begin
                if ((32'(count_reg) < capacity) && !saturated)
                begin
                    stored = 1'b1;
                end
                else
                begin
                    step_ovf = 1'b1;
                end
            end
            if (!saturated)
            begin
                step_count = count_reg + 1'b1;
            end
        end

        trunc = item.end_of_string && (step_rem != 2'd0);
    end

    always_comb
    begin
        rem_next       = rem_reg;
        part_next      = part_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_cp_next    = out_cp_reg;
        out_cpv_next   = out_cpv_reg;
        out_count_next = out_count_reg;
        out_done_next  = out_done_reg;
        out_ovf_next   = out_ovf_reg;
        out_trunc_next = out_trunc_reg;

        if (pop)
        begin
            out_valid_next = stored || item.end_of_string;
            out_cp_next    = stored ? step_cp : '0;
            out_cpv_next   = stored;
            out_count_next = utcd_pkg::OUT_COUNT_W'(step_count);
            out_done_next  = item.end_of_string;
            out_ovf_next   = step_ovf;
            out_trunc_next = trunc;
            if (item.end_of_string)
            begin
                rem_next   = '0;
                part_next  = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                rem_next   = step_rem;
                part_next  = step_part;
                count_next = step_count;
                ovf_next   = step_ovf;
            end
        end
        else if (cp_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            part_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            part_reg      <= part_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cp_reg    <= out_cp_next;
        out_cpv_reg   <= out_cpv_next;
        out_count_reg <= out_count_next;
        out_done_reg  <= out_done_next;
        out_ovf_reg   <= out_ovf_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign cp_out.valid            = out_valid_reg;
    assign cp_out.code_point       = out_cp_reg;
    assign cp_out.code_point_valid = out_cpv_reg;
    assign cp_out.decoded_count    = out_count_reg;
    assign cp_out.string_done      = out_done_reg;
    assign cp_out.overflow         = out_ovf_reg;
    assign cp_out.truncated        = out_trunc_reg;

    a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_trunc_reg) |-> out_done_reg)
        else $error("truncated flag without end of string");

    a_stored_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cpv_reg) |-> !out_ovf_reg)
        else $error("code point stored after overflow");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.end_of_string) |=> (rem_reg == 2'd0 && count_reg == '0 && !ovf_reg))
        else $error("string state not cleared at end");

endmodule

// File: hw/rtl/utf8_to_codepoint_decoder.sv
// top level of the utf-8 to code point decoder
`timescale 1ns / 1ps

// usage:
//   utf8_bytes carries one utf-8 byte per word with end_of_string on the last
//   byte of each string; code_points carries decoded words back out.
//   a word appears for every completed code point that fits in capacity,
//   and always one for the last byte of a string, with string_done set,
//   the final count, the sticky overflow flag and the truncated flag.
//   cfg_we/cfg_wdata write capacity; zero means count only, so only the end
//   word comes out. write it only while no string is in flight.
// timing:
//   one byte per cycle sustained while code_points.ready is high; a byte's
//   word goes through a queue slot and then the output register, and leaves
//   when code_points.ready is high (front classifies straight into the queue,
//   back decodes out of it into the output register).
//   the back end does all of a byte's work as it pops it, which sets the rate.
// reset:
//   clears the queue, decode state, count and capacity; output goes idle.
// stalls:
//   while code_points.ready is low the output word holds, the back end stops
//   and the queue fills; utf8_bytes.ready drops only when the queue is full.

module utf8_to_codepoint_decoder
#(
    parameter int unsigned COUNT_WIDTH = utcd_pkg::COUNT_WIDTH_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = utcd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [utcd_pkg::CAP_W-1:0]  cfg_wdata,
    utcd_byte_if.sink                   utf8_bytes,
    utcd_cp_if.source                   code_points
);

    // capacity register, read live by the back end
    logic [utcd_pkg::CAP_W-1:0] capacity_reg, capacity_next;

    // front to queue
    logic                 push;
    utcd_pkg::utcd_item_t push_item;

    // queue to back
    logic                 pop;
    utcd_pkg::utcd_item_t pop_item;
    logic                 queue_full;
    logic                 queue_empty;

    always_comb
    begin
        capacity_next = cfg_we ? cfg_wdata : capacity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // classify incoming bytes
    utcd_front u_front
    (
        .byte_in    (utf8_bytes),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // decouples the input handshake from output stalls
    utcd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // sequence assembly, counting and the output register
    utcd_back
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .queue_empty (queue_empty),
        .item        (pop_item),
        .pop         (pop),
        .cp_out      (code_points)
    );

endmodule
